[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL. Both sample on clk and are
// disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/pbrc_pkg.sv]
`default_nettype none

package pbrc_pkg;

  // Number of entries in the button table.
  localparam int TABLE_ENTRIES = 6;
  // Entries that receive the mirrored X, Y and Z in three-button mode.
  localparam int MIRROR_OFFSET = 3;

  // Button codes as stored in the table.
  localparam logic [2:0] BTN_NONE = 3'd0;
  localparam logic [2:0] BTN_A    = 3'd1;
  localparam logic [2:0] BTN_B    = 3'd2;
  localparam logic [2:0] BTN_C    = 3'd3;
  localparam logic [2:0] BTN_X    = 3'd4;
  localparam logic [2:0] BTN_Y    = 3'd5;
  localparam logic [2:0] BTN_Z    = 3'd6;

  // Register indexes on the configuration port.
  localparam logic REG_HOLD_OFF = 1'b0;
  localparam logic REG_BLINK    = 1'b1;

  // Configuration reset values.
  localparam logic [15:0] HOLD_OFF_RESET = 16'd100;
  localparam logic [15:0] BLINK_RESET    = 16'd250;

  typedef logic [2:0] btn_code_t;
  typedef btn_code_t [TABLE_ENTRIES-1:0] btn_table_t;

  // Table contents after reset: B, C, A, Y, Z, X for entries 0 to 5.
  localparam btn_table_t TABLE_DEFAULT = {BTN_X, BTN_Z, BTN_Y, BTN_A, BTN_C, BTN_B};

  typedef struct packed {
    logic [15:0] hold_off_ticks;
    logic [15:0] blink_ticks;
  } cfg_t;

  typedef struct packed {
    logic [5:0] pad_buttons;
    logic       other_pressed;
    logic       start_full;
    logic       start_three;
  } in_word_t;

  typedef struct packed {
    logic [2:0] map_left;
    logic [2:0] map_right;
    logic [2:0] map_both;
    logic [2:0] map_auto_left;
    logic [2:0] map_auto_right;
    logic [2:0] map_auto_both;
    logic       remapping;
    logic       led_level;
    logic       save_pulse;
  } out_word_t;

endpackage

`default_nettype wire

[hdl/pbrc_cfg.sv]
`default_nettype none

module pbrc_cfg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output pbrc_pkg::cfg_t     cfg
);
  import pbrc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register write decode; the word address is paddr[2].
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_HOLD_OFF: cfg_nxt.hold_off_ticks = pwdata[15:0];
        REG_BLINK:    cfg_nxt.blink_ticks    = pwdata[15:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_off_ticks <= HOLD_OFF_RESET;
      cfg_r.blink_ticks    <= BLINK_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back.
  always_comb begin
    unique case (paddr[2])
      REG_HOLD_OFF: prdata = {16'd0, cfg_r.hold_off_ticks};
      REG_BLINK:    prdata = {16'd0, cfg_r.blink_ticks};
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[hdl/pbrc_core.sv]
`default_nettype none

module pbrc_core #(
  parameter int TIMER_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pbrc_pkg::cfg_t     cfg,
  input  wire logic               in_valid,
  input  wire pbrc_pkg::in_word_t in_data,
  output logic                    in_stall,
  input  wire logic               res_ready,
  output logic                    res_valid,
  output pbrc_pkg::out_word_t     res_data
);
  import pbrc_pkg::*;

  localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam logic [TIMER_BITS-1:0] TMAX   = {TIMER_BITS{1'b1}};
  localparam logic [CMP_W-1:0]      TMAX_W = CMP_W'(TMAX);
  localparam logic [2:0] SLOTS_FULL   = 3'(TABLE_ENTRIES);
  localparam logic [2:0] SLOTS_MIRROR = 3'(MIRROR_OFFSET);

  // Input register.
  in_word_t in_r;
  logic     in_valid_r;
  logic     fire;

  // Remap state.
  btn_table_t            table_r,   table_nxt;
  logic [2:0]            slot_r,    slot_nxt;
  logic                  active_r,  active_nxt;
  logic                  mirror_r,  mirror_nxt;
  logic [TIMER_BITS-1:0] hold_r,    hold_nxt;
  logic                  blink_r,   blink_nxt;
  logic                  led_r,     led_nxt;
  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt;
  logic                  saved;

  assign fire      = in_valid_r && res_ready;
  assign in_stall  = in_valid_r && !res_ready;
  assign res_valid = fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  // One tick: start requests, then capture, then blink.
  always_comb begin
    logic                  started;
    logic [2:0]            code;
    logic [2:0]            limit;
    logic                  dup;
    logic [TIMER_BITS-1:0] hold_dec;
    logic [CMP_W-1:0]      hold_sat;
    logic [2:0]            slot_inc;

    table_nxt   = table_r;
    slot_nxt    = slot_r;
    active_nxt  = active_r;
    mirror_nxt  = mirror_r;
    hold_nxt    = hold_r;
    blink_nxt   = blink_r;
    led_nxt     = led_r;
    elapsed_nxt = elapsed_r;
    saved       = 1'b0;
    code        = BTN_NONE;
    dup         = 1'b0;
    hold_dec    = '0;
    slot_inc    = '0;

    // Start request; the three-button request wins.
    started = in_r.start_three || in_r.start_full;
    if (started) begin
      table_nxt  = '0;
      slot_nxt   = '0;
      active_nxt = 1'b1;
      mirror_nxt = in_r.start_three;
      hold_nxt   = '0;
      if (!blink_r) begin
        blink_nxt   = 1'b1;
        led_nxt     = 1'b0;
        elapsed_nxt = '0;
      end
    end

    // Capture of a sole pressed button.
    if (!in_r.other_pressed) begin
      for (int i = 0; i < 6; i++) begin
        if (in_r.pad_buttons == (6'b1 << i)) begin
          code = 3'(i + 1);
        end
      end
    end
    limit = mirror_nxt ? SLOTS_MIRROR : slot_nxt;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if ((3'(i) < limit) && (table_nxt[i] == code)) begin
        dup = 1'b1;
      end
    end
    hold_sat = (CMP_W'(cfg.hold_off_ticks) > TMAX_W) ? TMAX_W
                                                     : CMP_W'(cfg.hold_off_ticks);

    if (active_nxt) begin
      hold_dec = (hold_nxt != '0) ? (hold_nxt - 1'b1) : hold_nxt;
      hold_nxt = hold_dec;
      if ((hold_dec == '0) && (code != BTN_NONE) && !(mirror_nxt && code > BTN_C) &&
          !dup) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (slot_nxt == 3'(i)) begin
            table_nxt[i] = code;
          end
          if (mirror_nxt && (slot_nxt == 3'(i - MIRROR_OFFSET)) && (i >= MIRROR_OFFSET)) begin
            table_nxt[i] = code + 3'(MIRROR_OFFSET);
          end
        end
        slot_inc = slot_nxt + 3'd1;
        if (slot_inc >= (mirror_nxt ? SLOTS_MIRROR : SLOTS_FULL)) begin
          active_nxt = 1'b0;
          slot_nxt   = '0;
          mirror_nxt = 1'b0;
          blink_nxt  = 1'b0;
          led_nxt    = 1'b1;
          saved      = 1'b1;
        end else begin
          slot_nxt = slot_inc;
          hold_nxt = hold_sat[TIMER_BITS-1:0];
        end
      end
    end

    // LED blink, skipped on the tick that just started it.
    if (!(started && elapsed_nxt == '0 && !led_nxt) && blink_nxt) begin
      if (elapsed_nxt != TMAX) begin
        elapsed_nxt = elapsed_nxt + 1'b1;
      end
      if (CMP_W'(elapsed_nxt) >= CMP_W'(cfg.blink_ticks)) begin
        elapsed_nxt = '0;
        led_nxt     = !led_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_r   <= TABLE_DEFAULT;
      slot_r    <= '0;
      active_r  <= 1'b0;
      mirror_r  <= 1'b0;
      hold_r    <= '0;
      blink_r   <= 1'b0;
      led_r     <= 1'b1;
      elapsed_r <= '0;
    end else if (fire) begin
      table_r   <= table_nxt;
      slot_r    <= slot_nxt;
      active_r  <= active_nxt;
      mirror_r  <= mirror_nxt;
      hold_r    <= hold_nxt;
      blink_r   <= blink_nxt;
      led_r     <= led_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  // Result word of this tick.
  always_comb begin
    res_data.map_left       = table_nxt[0];
    res_data.map_right      = table_nxt[1];
    res_data.map_both       = table_nxt[2];
    res_data.map_auto_left  = table_nxt[3];
    res_data.map_auto_right = table_nxt[4];
    res_data.map_auto_both  = table_nxt[5];
    res_data.remapping      = active_nxt;
    res_data.led_level      = led_nxt;
    res_data.save_pulse     = saved;
  end

endmodule

`default_nettype wire

[hdl/pbrc_out.sv]
`default_nettype none

module pbrc_out (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                res_valid,
  input  wire pbrc_pkg::out_word_t res_data,
  output logic                     res_ready,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pbrc_pkg::out_word_t      out_data
);
  import pbrc_pkg::*;

  logic      out_valid_r;
  out_word_t out_data_r;

  // The register takes a new word when empty or when its word leaves now.
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[hdl/pad_button_remap_capture.sv]
// Channel   Direction  Handshake           Word
// in_       input      in_valid/in_stall   in_word_t (pad sample, start requests)
// out_      output     out_valid/out_stall out_word_t (table, status, LED, save)
// config    APB        psel/penable/pready 16-bit hold-off and blink registers
//
// One word per clock is accepted while in_stall is low; an accepted word sits in
// the input register while the tick logic works on it, and the result register
// takes it once that register is free. The input register can take one more
// word while a result waits. Synchronous active-low reset restores the default
// table and the register defaults; no clearing pass. A stall on out_ backs up
// into in_stall only once both the result and input registers are full.
`default_nettype none

module pad_button_remap_capture #(
  parameter int TIMER_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire pbrc_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pbrc_pkg::out_word_t      out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready
);
  import pbrc_pkg::*;

  `include "assert_macros.svh"

  cfg_t      cfg;
  logic      res_valid;
  logic      res_ready;
  out_word_t res_data;

  pbrc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pbrc_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  pbrc_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The input side only stalls while the result register is held.
  `ASSERT_IMPLIES(a_stall_only_when_full, in_stall, out_valid && out_stall, "in_stall without held result")
  // A completed remap reports idle with the LED high.
  `ASSERT_IMPLIES(a_save_ends_remap, out_valid && out_data.save_pulse, !out_data.remapping && out_data.led_level, "save without remap end")
  // Outside a remap the LED is never low.
  `ASSERT_IMPLIES(a_led_idle_high, out_valid && !out_data.remapping, out_data.led_level, "LED low while idle")
  // A word that leaves the tick logic while the result side is free shows up next cycle.
  `ASSERT_NEXT(a_result_lands, res_valid && res_ready, out_valid, "result word lost")

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pbrc_pkg::*;

  // Cycles with no word moving on either channel and no register access before the run is declared hung.
  localparam int QUIET_LIMIT = 4000;

  // Predicts the table, status, LED and save pulse for every accepted word and
  // checks the results in order.
  class remap_scoreboard;
    logic [15:0] hold_off_cfg;
    logic [15:0] blink_cfg;
    btn_table_t  tbl;
    logic [2:0]  slot;
    bit          active;
    bit          mirror;
    bit          blink_run;
    bit          led;
    logic [15:0] hold_left;
    logic [15:0] blink_count;
    out_word_t   pending[$];
    int          errors;
    int          words_in;
    int          saves;

    function new();
      hold_off_cfg = HOLD_OFF_RESET;
      blink_cfg    = BLINK_RESET;
      tbl          = TABLE_DEFAULT;
      slot         = '0;
      active       = 1'b0;
      mirror       = 1'b0;
      blink_run    = 1'b0;
      led          = 1'b1;
      hold_left    = '0;
      blink_count  = '0;
      errors       = 0;
      words_in     = 0;
      saves        = 0;
    endfunction

    // One tick: start requests first, then the capture, then the blink.
    function void note_input(in_word_t w);
      bit        started;
      bit        saved;
      bit        dup;
      btn_code_t code;
      int        lim;
      int        i;
      out_word_t exp_w;
      words_in++;
      started = w.start_three || w.start_full;
      saved   = 1'b0;

      // A start clears the table; the blink keeps its phase if already running.
      if (started) begin
        tbl       = '0;
        slot      = '0;
        active    = 1'b1;
        mirror    = w.start_three;
        hold_left = '0;
        if (!blink_run) begin
          blink_run   = 1'b1;
          led         = 1'b0;
          blink_count = '0;
        end
      end

      // Capture: only a sole face button, no duplicates, X/Y/Z refused when mirroring.
      if (active) begin
        if (hold_left != 0) hold_left--;
        if (hold_left == 0) begin
          code = BTN_NONE;
          if (!w.other_pressed && $countones(w.pad_buttons) == 1) begin
            for (i = 0; i < 6; i++) begin
              if (w.pad_buttons[i]) code = btn_code_t'(BTN_A + i);
            end
          end
          dup = 1'b0;
          lim = mirror ? MIRROR_OFFSET : int'(slot);
          for (i = 0; i < lim; i++) begin
            if (tbl[i] == code) dup = 1'b1;
          end
          if (code != BTN_NONE && !(mirror && code > BTN_C) && !dup) begin
            tbl[slot] = code;
            if (mirror) tbl[slot + MIRROR_OFFSET] = code + (BTN_X - BTN_A);
            slot++;
            if (int'(slot) >= (mirror ? MIRROR_OFFSET : TABLE_ENTRIES)) begin
              active    = 1'b0;
              slot      = '0;
              mirror    = 1'b0;
              blink_run = 1'b0;
              led       = 1'b1;
              saved     = 1'b1;
              saves++;
            end else begin
              hold_left = hold_off_cfg;
            end
          end
        end
      end

      // The blink counter does not advance on the tick that started it.
      if (blink_run && !(started && blink_count == 0 && !led)) begin
        if (blink_count != 16'hFFFF) blink_count++;
        if (blink_count >= blink_cfg) begin
          blink_count = '0;
          led         = !led;
        end
      end

      exp_w.map_left       = tbl[0];
      exp_w.map_right      = tbl[1];
      exp_w.map_both       = tbl[2];
      exp_w.map_auto_left  = tbl[3];
      exp_w.map_auto_right = tbl[4];
      exp_w.map_auto_both  = tbl[5];
      exp_w.remapping      = active;
      exp_w.led_level      = led;
      exp_w.save_pulse     = saved;
      pending.push_back(exp_w);
    endfunction

    function void compare_field(string name, int unsigned e, int unsigned a);
      if (e != a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      if (pending.size() == 0) begin
        $error("result word arrived with no word outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      compare_field("map_left", e.map_left, got.map_left);
      compare_field("map_right", e.map_right, got.map_right);
      compare_field("map_both", e.map_both, got.map_both);
      compare_field("map_auto_left", e.map_auto_left, got.map_auto_left);
      compare_field("map_auto_right", e.map_auto_right, got.map_auto_right);
      compare_field("map_auto_both", e.map_auto_both, got.map_auto_both);
      compare_field("remapping", e.remapping, got.remapping);
      compare_field("led_level", e.led_level, got.led_level);
      compare_field("save_pulse", e.save_pulse, got.save_pulse);
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_word_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  remap_scoreboard sb = new();
  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet     = 0;
  int settings  = 0;

  pad_button_remap_capture uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Random receiver stall.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Monitor both channels and watch for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("[pad_button_remap_capture] ERROR");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  function automatic logic [5:0] pad_of(btn_code_t c);
    return 6'(1) << (c - BTN_A);
  endfunction

  function automatic in_word_t make_word(logic [5:0] pad, bit other, bit full, bit three);
    in_word_t w;
    w.pad_buttons   = pad;
    w.other_pressed = other;
    w.start_full    = full;
    w.start_three   = three;
    return w;
  endfunction

  // A tick of random content: often nothing pressed, sometimes junk or a single button, rarely a start.
  function automatic in_word_t noise_word();
    in_word_t w;
    int       r;
    w = '0;
    r = $urandom_range(99);
    if (r < 25) w.pad_buttons = 6'($urandom_range(63));
    else if (r < 50) w.pad_buttons = pad_of(btn_code_t'($urandom_range(BTN_Z, BTN_A)));
    w.other_pressed = ($urandom_range(99) < 15);
    r = $urandom_range(99);
    if (r == 0) w.start_full = 1'b1;
    else if (r == 1) w.start_three = 1'b1;
    else if (r == 2) begin
      w.start_full  = 1'b1;
      w.start_three = 1'b1;
    end
    return w;
  endfunction

  // Offer one word, with random sender idle time in front of it.
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // Drain all outstanding words so the block is idle. The first edge lets the
  // monitor note a word that was accepted at the current edge.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_HOLD_OFF) sb.hold_off_cfg = value;
    else sb.blink_cfg = value;
  endtask

  task automatic configure(logic [15:0] hold, logic [15:0] blink);
    settle();
    write_reg(REG_HOLD_OFF, hold);
    write_reg(REG_BLINK, blink);
    settings++;
  endtask

  // One remap attempt: a start, then the wanted buttons in random order with
  // noise ticks between them to cover the hold-off.
  task automatic remap_session(int hold);
    btn_code_t order[6];
    btn_code_t t;
    int        n;
    int        r;
    int        i;
    int        j;
    int        gap;
    r = $urandom_range(2);
    n = (r == 0) ? TABLE_ENTRIES : MIRROR_OFFSET;
    send_word(make_word(($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'd0,
                        $urandom_range(1), r != 1, r != 0));
    for (i = 0; i < n; i++) order[i] = btn_code_t'(BTN_A + i);
    for (i = n - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (i = 0; i < n; i++) begin
      gap = ((hold < 6) ? hold : 6) - 1 + $urandom_range(2);
      repeat (gap) send_word(noise_word());
      send_word(make_word(pad_of(order[i]), $urandom_range(19) == 0, 1'b0, 1'b0));
    end
    repeat ($urandom_range(4)) send_word(noise_word());
  endtask

  task automatic run_phase(logic [15:0] hold, logic [15:0] blink, int idle, int stall,
                           int count);
    int target;
    configure(hold, blink);
    idle_pct  = idle;
    stall_pct = stall;
    target    = sb.words_in + count;
    while (sb.words_in < target) remap_session(hold);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a capture on the start tick, then one blocked by the hold-off.
    send_word(make_word(pad_of(BTN_A), 1'b0, 1'b1, 1'b0));
    send_word(make_word(pad_of(BTN_B), 1'b0, 1'b0, 1'b0));
    send_word(make_word(6'd0, 1'b0, 1'b0, 1'b0));

    // Full remap with refused presses mixed in, ending in a save pulse.
    configure(16'd1, 16'd3);
    send_word(make_word(pad_of(BTN_A), 1'b0, 1'b1, 1'b0));
    send_word(make_word(pad_of(BTN_A), 1'b0, 1'b0, 1'b0));
    send_word(make_word(pad_of(BTN_A) | pad_of(BTN_B), 1'b0, 1'b0, 1'b0));
    send_word(make_word(pad_of(BTN_B), 1'b1, 1'b0, 1'b0));
    send_word(make_word(6'd0, 1'b0, 1'b0, 1'b0));
    send_word(make_word(pad_of(BTN_B), 1'b0, 1'b0, 1'b0));
    send_word(make_word(pad_of(BTN_C), 1'b0, 1'b0, 1'b0));
    send_word(make_word(pad_of(BTN_X), 1'b0, 1'b0, 1'b0));
    send_word(make_word(pad_of(BTN_Y), 1'b0, 1'b0, 1'b0));
    send_word(make_word(pad_of(BTN_Z), 1'b0, 1'b0, 1'b0));

    // Both starts at once: three-button mode wins; X refused, a restart mid-way.
    send_word(make_word(pad_of(BTN_X), 1'b0, 1'b1, 1'b1));
    send_word(make_word(pad_of(BTN_A), 1'b0, 1'b0, 1'b0));
    send_word(make_word(pad_of(BTN_A), 1'b0, 1'b0, 1'b0));
    send_word(make_word(6'd0, 1'b0, 1'b0, 1'b1));
    send_word(make_word(pad_of(BTN_Z), 1'b0, 1'b0, 1'b0));
    send_word(make_word(pad_of(BTN_B), 1'b0, 1'b0, 1'b0));
    send_word(make_word(pad_of(BTN_C), 1'b0, 1'b0, 1'b0));
    send_word(make_word(pad_of(BTN_A), 1'b0, 1'b0, 1'b0));

    // Everything held while idle, then a restart while the LED blinks.
    send_word(make_word(6'h3F, 1'b1, 1'b0, 1'b0));
    send_word(make_word(6'd0, 1'b0, 1'b1, 1'b0));
    send_word(make_word(6'd0, 1'b0, 1'b0, 1'b0));
    send_word(make_word(6'd0, 1'b0, 1'b0, 1'b0));
    send_word(make_word(6'd0, 1'b0, 1'b1, 1'b0));
    send_word(make_word(6'd0, 1'b0, 1'b0, 1'b0));
    send_word(make_word(6'd0, 1'b0, 1'b0, 1'b0));

    // Random sessions under several register settings and pacing patterns.
    run_phase(16'd1, 16'd1, 0, 0, 300);
    run_phase(16'd3, 16'd17, 86, 0, 250);
    run_phase(16'hFFFF, 16'hFFFF, 0, 86, 150);
    run_phase(16'd2, 16'd6, 30, 30, 300);
    run_phase(16'd1, 16'd40, 0, 0, 220);

    settle();
    repeat (6) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d result words never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("Ran %0d ticks through %0d register settings; %0d remaps completed with a save.",
             sb.words_in, settings, sb.saves);
    $display("Pacing covered free flow, heavy sender idling, heavy result stalls and both.");
    if (sb.errors == 0) begin
      $display("[pad_button_remap_capture] OK");
    end else begin
      $display("[pad_button_remap_capture] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[pad_button_remap_capture.f]
+incdir+hdl
hdl/pbrc_pkg.sv
hdl/pbrc_cfg.sv
hdl/pbrc_core.sv
hdl/pbrc_out.sv
hdl/pad_button_remap_capture.sv
tb/sv/tb_top.sv
